[hdl/jpgs_pkg.sv]
// Package: shared types and constants for the joint position gate and smoother.
package jpgs_pkg;

    localparam int POS_W          = 16;
    localparam int WINDOW_LEN_DEF = 8;
    localparam int QUEUE_DEPTH    = 2;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic is_head;
        t_pos x;
        t_pos y;
        t_pos z;
    } t_item;

    typedef struct packed {
        t_pos x;
        t_pos y;
        t_pos z;
    } t_hist;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

[hdl/jpgs_in_if.sv]
// Interface: input sample channel.
interface jpgs_in_if import jpgs_pkg::*;;
    logic valid;
    logic ready;
    logic body_tracked;
    logic joint_tracked;
    logic is_head;
    t_pos pos_x;
    t_pos pos_y;
    t_pos pos_z;

    modport source (output valid, output body_tracked, output joint_tracked,
                    output is_head, output pos_x, output pos_y, output pos_z,
                    input ready);
    modport sink   (input valid, input body_tracked, input joint_tracked,
                    input is_head, input pos_x, input pos_y, input pos_z,
                    output ready);
endinterface

[hdl/jpgs_out_if.sv]
// Interface: result channel.
interface jpgs_out_if import jpgs_pkg::*;;
    logic valid;
    logic ready;
    t_pos out_x;
    t_pos out_y;
    t_pos out_z;

    modport source (output valid, output out_x, output out_y, output out_z,
                    input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    output ready);
endinterface

[hdl/jpgs_front.sv]
// Front end: accept samples, drop untracked ones, apply the saturated offset.
module jpgs_front import jpgs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_pos       i_cfg_data,
    jpgs_in_if.sink    i_in,
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_item      o_item
);

    t_pos               r_offset;
    logic signed [POS_W:0] w_diff;
    t_pos               w_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_data;
        end
    end

    always_comb begin
        w_diff = (POS_W+1)'(i_in.pos_y) - (POS_W+1)'(r_offset);
        if (w_diff[POS_W] != w_diff[POS_W-1]) begin
            w_y = w_diff[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            w_y = w_diff[POS_W-1:0];
        end
    end

    assign i_in.ready     = !i_q_stat.full;
    assign o_push         = i_in.valid && i_in.ready && i_in.body_tracked
                            && i_in.joint_tracked;
    assign o_item.is_head = i_in.is_head;
    assign o_item.x       = i_in.pos_x;
    assign o_item.y       = w_y;
    assign o_item.z       = i_in.pos_z;

endmodule

[hdl/jpgs_queue.sv]
// Queue: short item buffer between the front end and the back end.
module jpgs_queue import jpgs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_item   o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_item              r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

    assign o_stat.full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign o_item       = r_buf[r_rd_ptr];

endmodule

[hdl/jpgs_back.sv]
// Back end: head history ring, running sums and the output register.
module jpgs_back import jpgs_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_item      i_item,
    output logic       o_pop,
    jpgs_out_if.source o_out
);

    localparam int K      = $clog2(WINDOW_LEN);
    localparam int SLOT_W = K;
    localparam int SUM_W  = POS_W + K;

    typedef logic signed [SUM_W-1:0] t_sum;

    t_hist              r_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] r_mem_vld;
    t_hist              r_rd;
    logic               r_rd_vld;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_a_valid;
    t_item              r_a;
    logic [SLOT_W-1:0]  r_a_slot;
    t_sum               r_sum_x;
    t_sum               r_sum_y;
    t_sum               r_sum_z;
    logic               r_o_valid;
    t_hist              r_o;
    t_hist              w_old;
    t_sum               n_sum_x;
    t_sum               n_sum_y;
    t_sum               n_sum_z;
    logic               w_a_adv;
    logic               w_head_upd;

    assign w_a_adv    = r_a_valid && (!r_o_valid || o_out.ready);
    assign o_pop      = i_q_stat.valid && (!r_a_valid || w_a_adv);
    assign w_head_upd = w_a_adv && r_a.is_head;

    always_comb begin
        w_old   = r_rd_vld ? r_rd : '0;
        n_sum_x = r_sum_x + SUM_W'(r_a.x) - SUM_W'(w_old.x);
        n_sum_y = r_sum_y + SUM_W'(r_a.y) - SUM_W'(w_old.y);
        n_sum_z = r_sum_z + SUM_W'(r_a.z) - SUM_W'(w_old.z);
    end

    always_ff @(posedge i_clk) begin
        if (w_head_upd) begin
            r_mem[r_a_slot] <= '{x: r_a.x, y: r_a.y, z: r_a.z};
        end
        if (o_pop) begin
            r_rd     <= r_mem[r_slot];
            r_rd_vld <= r_mem_vld[r_slot];
            r_a      <= i_item;
            r_a_slot <= r_slot;
        end
        if (w_a_adv) begin
            if (r_a.is_head) begin
                r_o.x <= n_sum_x[K+POS_W-1:K];
                r_o.y <= n_sum_y[K+POS_W-1:K];
                r_o.z <= n_sum_z[K+POS_W-1:K];
            end else begin
                r_o.x <= r_a.x;
                r_o.y <= r_a.y;
                r_o.z <= r_a.z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_slot    <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_z   <= '0;
        end else begin
            if (w_head_upd) begin
                r_mem_vld[r_a_slot] <= 1'b1;
                r_sum_x             <= n_sum_x;
                r_sum_y             <= n_sum_y;
                r_sum_z             <= n_sum_z;
            end
            if (o_pop && i_item.is_head) begin
                r_slot <= r_slot + SLOT_W'(1);
            end
            if (o_pop) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.out_x = r_o.x;
    assign o_out.out_y = r_o.y;
    assign o_out.out_z = r_o.z;

endmodule

[hdl/joint_position_gate_and_smooth.sv]
// Top level: joint position gate and head smoother.
// Takes one joint sample per cycle while the queue is not full and gives a result
// for each sample whose body and joint tracking flags are both set; untracked
// samples are consumed and dropped. The vertical offset register is subtracted
// from y with saturation. Head samples are averaged over the last WINDOW_LEN head
// positions (a power of two, 2 to 64) from running sums. A sample passes through
// the two-entry queue, the registered history memory read and the sum update into
// the output register. Sustained rate is one item per cycle while the output is not
// stalled, limited by the single read and write port of the history memory.
module joint_position_gate_and_smooth import jpgs_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_pos       i_cfg_data,
    jpgs_in_if.sink    i_in,
    jpgs_out_if.source o_out
);

    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;
    t_item   w_push_item;
    t_item   w_pop_item;

    jpgs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    jpgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_item  (w_pop_item)
    );

    jpgs_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_item   (w_pop_item),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

`ifndef NO_ASSERTIONS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_stat.valid)
        else $error("pop from empty queue");

    a_drop_untracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !(i_in.body_tracked && i_in.joint_tracked))
        |-> !w_push)
        else $error("untracked item entered queue");

    a_push_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_q_stat.valid && !w_push) |=> !w_q_stat.valid)
        else $error("queue filled without push");
`endif

endmodule

[test/tb.sv]
// Testbench for the joint position gate and head smoother: directed and random samples.
`timescale 1ns / 100ps

module tb;
    import jpgs_pkg::*;

    localparam int WINDOW_LEN = WINDOW_LEN_DEF;
    localparam int WIN_SHIFT  = $clog2(WINDOW_LEN);

    typedef struct packed {
        t_pos x;
        t_pos y;
        t_pos z;
    } t_point;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_pos i_cfg_data;

    jpgs_in_if  in_ch ();
    jpgs_out_if out_ch ();

    joint_position_gate_and_smooth #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_hist  head_ring [WINDOW_LEN];
    int     ring_sum_x;
    int     ring_sum_y;
    int     ring_sum_z;
    int     ring_slot;
    t_pos   y_offset;
    t_point pending_points [$];
    int     mismatch_count;
    int     stall_left;
    bit     idle_on;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_pos rand_pos();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return '0;
            3: return -16'sh1;
            4, 5: return t_pos'(int'($urandom_range(0, 64)) - 32);
            default: return t_pos'($urandom);
        endcase
    endfunction

    function automatic t_item mk_item(logic head, t_pos x, t_pos y, t_pos z);
        t_item s;
        s.is_head = head;
        s.x = x;
        s.y = y;
        s.z = z;
        return s;
    endfunction

    task automatic clear_smoother();
        foreach (head_ring[i]) head_ring[i] = '0;
        ring_sum_x = 0;
        ring_sum_y = 0;
        ring_sum_z = 0;
        ring_slot  = 0;
        y_offset   = '0;
    endtask

    function automatic bit smooth_joint(input logic body, input logic joint, input t_item smp,
                                        output t_point res);
        int    yd;
        t_hist fresh;
        if (!(body && joint)) return 1'b0;
        yd = int'(smp.y) - int'(y_offset);
        if (yd > 32767) yd = 32767;
        else if (yd < -32768) yd = -32768;
        res.x = smp.x;
        res.y = t_pos'(yd);
        res.z = smp.z;
        if (smp.is_head) begin
            fresh.x = res.x;
            fresh.y = res.y;
            fresh.z = res.z;
            ring_sum_x += int'(fresh.x) - int'(head_ring[ring_slot].x);
            ring_sum_y += int'(fresh.y) - int'(head_ring[ring_slot].y);
            ring_sum_z += int'(fresh.z) - int'(head_ring[ring_slot].z);
            head_ring[ring_slot] = fresh;
            ring_slot = (ring_slot + 1) % WINDOW_LEN;
            res.x = t_pos'(ring_sum_x >>> WIN_SHIFT);
            res.y = t_pos'(ring_sum_y >>> WIN_SHIFT);
            res.z = t_pos'(ring_sum_z >>> WIN_SHIFT);
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 50) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic send_sample(input logic body, input logic joint, input t_item smp);
        int     gap;
        t_point res;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.body_tracked  <= body;
        in_ch.joint_tracked <= joint;
        in_ch.is_head       <= smp.is_head;
        in_ch.pos_x         <= smp.x;
        in_ch.pos_y         <= smp.y;
        in_ch.pos_z         <= smp.z;
        do @(posedge i_clk); while (!in_ch.ready);
        if (smooth_joint(body, joint, smp, res)) pending_points.push_back(res);
    endtask

    task automatic send_random(input int head_pct);
        logic body;
        logic joint;
        body  = ($urandom_range(0, 9) != 0);
        joint = ($urandom_range(0, 9) != 0);
        send_sample(body, joint,
                    mk_item($urandom_range(0, 99) < head_pct, rand_pos(), rand_pos(), rand_pos()));
    endtask

    task automatic settle_block();
        int waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_points.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_offset(input t_pos v);
        settle_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        y_offset = v;
    endtask

    always @(posedge i_clk) begin : result_check
        t_point want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d z=%0d",
                                          out_ch.out_x, out_ch.out_y, out_ch.out_z));
            end else begin
                want = pending_points.pop_front();
                if (out_ch.out_x !== want.x)
                    report_mismatch($sformatf("x got %0d want %0d", out_ch.out_x, want.x));
                if (out_ch.out_y !== want.y)
                    report_mismatch($sformatf("y got %0d want %0d", out_ch.out_y, want.y));
                if (out_ch.out_z !== want.z)
                    report_mismatch($sformatf("z got %0d want %0d", out_ch.out_z, want.z));
            end
        end
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    task automatic test_directed();
        send_sample(1'b0, 1'b0, mk_item(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        send_sample(1'b0, 1'b1, mk_item(1'b1, -16'sh8000, -16'sh8000, -16'sh8000));
        send_sample(1'b1, 1'b0, mk_item(1'b1, 16'sh7fff, -16'sh8000, 16'sh7fff));
        send_sample(1'b1, 1'b1, mk_item(1'b0, 16'sh7fff, -16'sh8000, 16'sh0));
        send_sample(1'b1, 1'b1, mk_item(1'b0, -16'sh8000, 16'sh7fff, -16'sh1));
        // warm-up: ring still holds zeros
        send_sample(1'b1, 1'b1, mk_item(1'b1, 16'sd1000, -16'sd3, 16'sd7));
        send_sample(1'b0, 1'b0, mk_item(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        send_sample(1'b1, 1'b1, mk_item(1'b1, -16'sd1, -16'sd1, -16'sd1));
        repeat (WINDOW_LEN) send_sample(1'b1, 1'b1,
                                        mk_item(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        repeat (WINDOW_LEN / 2) send_sample(1'b1, 1'b1,
                                            mk_item(1'b1, -16'sh8000, -16'sh8000, -16'sh8000));
        // offset overflow both ways
        write_offset(16'sh7fff);
        send_sample(1'b1, 1'b1, mk_item(1'b0, 16'sd5, -16'sh8000, 16'sd5));
        send_sample(1'b1, 1'b1, mk_item(1'b1, 16'sd5, -16'sh8000, 16'sd5));
        write_offset(-16'sh8000);
        send_sample(1'b1, 1'b1, mk_item(1'b0, -16'sd5, 16'sh7fff, -16'sd5));
        send_sample(1'b1, 1'b1, mk_item(1'b1, -16'sd5, 16'sh7fff, -16'sd5));
    endtask

    task automatic test_random_phases();
        t_pos offsets [5];
        offsets[0] = -16'sh8000;
        offsets[1] = 16'sh7fff;
        offsets[2] = t_pos'($urandom);
        offsets[3] = '0;
        offsets[4] = t_pos'(int'($urandom_range(0, 2048)) - 1024);
        foreach (offsets[p]) begin
            write_offset(offsets[p]);
            repeat (90) send_random($urandom_range(30, 90));
        end
    endtask

    task automatic test_pressure_pause();
        write_offset(t_pos'($urandom));
        repeat (15) send_random(60);
        settle_block();
        repeat (15) send_random(60);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (40) send_sample(1'b1, 1'b1,
                                mk_item($urandom_range(0, 9) != 0, rand_pos(), rand_pos(),
                                        rand_pos()));
        idle_on = 1'b1;
    endtask

    initial begin
        mismatch_count = 0;
        stall_left     = 0;
        idle_on        = 1'b1;
        clear_smoother();
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_data          <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.body_tracked  <= 1'b0;
        in_ch.joint_tracked <= 1'b0;
        in_ch.is_head       <= 1'b0;
        in_ch.pos_x         <= '0;
        in_ch.pos_y         <= '0;
        in_ch.pos_z         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phases();
        test_pressure_pause();
        test_back_to_back();

        settle_block();
        repeat (8) @(posedge i_clk);
        foreach (pending_points[i])
            report_mismatch($sformatf("missing result x=%0d y=%0d z=%0d", pending_points[i].x,
                                      pending_points[i].y, pending_points[i].z));
        if (mismatch_count == 0) begin
            $display("joint_position_gate_and_smooth verification clean");
        end else begin
            $display("joint_position_gate_and_smooth verification failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("joint_position_gate_and_smooth verification failed");
        $finish;
    end

endmodule
